### sv/rfpf_pkg.sv
// Shared types, constants, the microcode table and saturation helpers of the resonant filter.
`timescale 1ns / 1ps

package rfpf_pkg;

    // Sample and pole formats.
    localparam int SAMPLE_BITS = 24;
    localparam int POLE_BITS   = 32;
    localparam int NUM_POLES   = 4;
    localparam int POLE_IDX_W  = 2;

    // Register widths.
    localparam int CUTOFF_W = 16;
    localparam int OFFSET_W = 17;
    localparam int RES_W    = 16;
    localparam int MODE_W   = 2;

    // Feedback gain is unsigned Q12.16; both coefficients enter the multiplier as signed.
    localparam int FB_W       = 28;
    localparam int COEF_W     = FB_W + 1;
    localparam int PROD_W     = COEF_W + POLE_BITS;
    localparam int FRAC_SHIFT = 16;

    // Feedback divider: (resonance << 17) / (65536 - cutoff), one quotient bit per cycle.
    localparam int DIV_N_W   = RES_W + 17;
    localparam int DIV_D_W   = 17;
    localparam int DIV_CNT_W = 6;

    // APB port.
    localparam int ADDR_W     = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    // Sequencer.
    localparam int STEP_W = 4;

    localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = 16'd32768;
    localparam logic [CUTOFF_W-1:0] CUTOFF_MAX   = 16'd65470;
    localparam logic [FB_W-1:0]     FEEDBACK_MAX = 28'hFFF_FFFF;
    localparam logic [DIV_D_W-1:0]  CUTOFF_ONE   = 17'h1_0000;
    localparam logic [STEP_W-1:0]   STEP_OUT     = 4'd15;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_CUTOFF_BASE      = 3'd0,
        REG_CUTOFF_OFFSET    = 3'd1,
        REG_RESONANCE_AMOUNT = 3'd2,
        REG_RESPONSE_MODE    = 3'd3,
        REG_SLOPE_SELECT     = 3'd4
    } reg_idx_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOWPASS     = 2'd0,
        MODE_BANDPASS    = 2'd1,
        MODE_HIGHPASS    = 2'd2,
        MODE_PASSTHROUGH = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        OP_SUB = 2'd0,
        OP_MUL = 2'd1,
        OP_ADD = 2'd2,
        OP_OUT = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        SRC_ACC  = 2'd0,
        SRC_X    = 2'd1,
        SRC_P0   = 2'd2,
        SRC_POLE = 2'd3
    } src_t;

    typedef enum logic {
        COEF_FB     = 1'b0,
        COEF_CUTOFF = 1'b1
    } coef_t;

    // One control word: operation, first operand, pole index, multiplier coefficient,
    // pole write enable, and a jump taken in two-pole mode.
    typedef struct packed {
        op_t                   op;
        src_t                  src;
        logic [POLE_IDX_W-1:0] rd;
        coef_t                 coef;
        logic                  wr;
        logic                  br_two;
        logic [STEP_W-1:0]     target;
    } ucode_t;

    function automatic ucode_t mk_word(input op_t op, input src_t src,
                                       input logic [POLE_IDX_W-1:0] rd, input coef_t coef,
                                       input logic wr, input logic br_two);
        ucode_t w;
        w.op     = op;
        w.src    = src;
        w.rd     = rd;
        w.coef   = coef;
        w.wr     = wr;
        w.br_two = br_two;
        w.target = STEP_OUT;
        return w;
    endfunction

    // The program: feedback term, then one subtract / multiply / accumulate triple per pole.
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        case (step)
            4'd0:    w = mk_word(OP_SUB, SRC_P0,   2'd1, COEF_FB,     1'b0, 1'b0);
            4'd1:    w = mk_word(OP_MUL, SRC_ACC,  2'd0, COEF_FB,     1'b0, 1'b0);
            4'd2:    w = mk_word(OP_ADD, SRC_X,    2'd0, COEF_FB,     1'b0, 1'b0);
            4'd3:    w = mk_word(OP_SUB, SRC_ACC,  2'd0, COEF_CUTOFF, 1'b0, 1'b0);
            4'd4:    w = mk_word(OP_MUL, SRC_ACC,  2'd0, COEF_CUTOFF, 1'b0, 1'b0);
            4'd5:    w = mk_word(OP_ADD, SRC_POLE, 2'd0, COEF_CUTOFF, 1'b1, 1'b0);
            4'd6:    w = mk_word(OP_SUB, SRC_ACC,  2'd1, COEF_CUTOFF, 1'b0, 1'b0);
            4'd7:    w = mk_word(OP_MUL, SRC_ACC,  2'd1, COEF_CUTOFF, 1'b0, 1'b0);
            4'd8:    w = mk_word(OP_ADD, SRC_POLE, 2'd1, COEF_CUTOFF, 1'b1, 1'b1);
            4'd9:    w = mk_word(OP_SUB, SRC_ACC,  2'd2, COEF_CUTOFF, 1'b0, 1'b0);
            4'd10:   w = mk_word(OP_MUL, SRC_ACC,  2'd2, COEF_CUTOFF, 1'b0, 1'b0);
            4'd11:   w = mk_word(OP_ADD, SRC_POLE, 2'd2, COEF_CUTOFF, 1'b1, 1'b0);
            4'd12:   w = mk_word(OP_SUB, SRC_ACC,  2'd3, COEF_CUTOFF, 1'b0, 1'b0);
            4'd13:   w = mk_word(OP_MUL, SRC_ACC,  2'd3, COEF_CUTOFF, 1'b0, 1'b0);
            4'd14:   w = mk_word(OP_ADD, SRC_POLE, 2'd3, COEF_CUTOFF, 1'b1, 1'b0);
            default: w = mk_word(OP_OUT, SRC_ACC,  2'd0, COEF_CUTOFF, 1'b0, 1'b0);
        endcase
        return w;
    endfunction

    // Clamp a wide signed value to the pole range.
    function automatic logic signed [POLE_BITS-1:0] sat_pole(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (POLE_BITS - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi) begin
            return hi[POLE_BITS-1:0];
        end
        if (v < lo) begin
            return lo[POLE_BITS-1:0];
        end
        return v[POLE_BITS-1:0];
    endfunction

    // Clamp a wide signed value to the sample range.
    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi) begin
            return hi[SAMPLE_BITS-1:0];
        end
        if (v < lo) begin
            return lo[SAMPLE_BITS-1:0];
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

endpackage

### sv/resonant_four_pole_filter.sv
// Top level of the resonant two/four-pole filter: APB registers, feedback divider and sequencer.
`timescale 1ns / 1ps

// The filter takes one signed Q1.23 request on the input channel and returns one filtered
// Q1.23 sample on the output channel. Each nonzero sample runs through a short microcode
// program on a single multiply-accumulate datapath; a two-pole request leaves it early, and
// a zero sample (which returns zero and leaves the poles alone) goes straight to its output
// step. The program runs one step per cycle through one 29 x 32 multiplier, but waits at
// the output step until the output register is free. A new request is accepted while the
// previous result still waits on the output register. Every write to one of the five
// registers starts a bit-serial division for the resonance feedback gain; the input channel
// holds ready low until it finishes. Registers sit at byte addresses 0, 4, 8, 12 and 16:
// cutoff_base, cutoff_offset, resonance_amount, response_mode and slope_select.
module resonant_four_pole_filter
    import rfpf_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ADDR_W-1:0]             paddr,
    input  logic [APB_DATA_W-1:0]         pwdata,
    output logic [APB_DATA_W-1:0]         prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] sample_out
);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [CUTOFF_W-1:0]        cutoff_base_reg;
    logic signed [OFFSET_W-1:0] cutoff_offset_reg;
    logic [RES_W-1:0]           resonance_amount_reg;
    logic [MODE_W-1:0]          response_mode_reg;
    logic                       slope_select_reg;

    logic     cfg_wr;
    logic     cfg_hit;
    reg_idx_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

    // Only writes that land on a real register change the feedback gain.
    always_comb
    begin
        unique case (cfg_idx)
            REG_CUTOFF_BASE, REG_CUTOFF_OFFSET, REG_RESONANCE_AMOUNT,
            REG_RESPONSE_MODE, REG_SLOPE_SELECT: cfg_hit = cfg_wr;
            default:                             cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_base_reg      <= CUTOFF_RESET;
            cutoff_offset_reg    <= '0;
            resonance_amount_reg <= '0;
            response_mode_reg    <= MODE_LOWPASS;
            slope_select_reg     <= 1'b1;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_CUTOFF_BASE:      cutoff_base_reg      <= pwdata[CUTOFF_W-1:0];
                REG_CUTOFF_OFFSET:    cutoff_offset_reg    <= pwdata[OFFSET_W-1:0];
                REG_RESONANCE_AMOUNT: resonance_amount_reg <= pwdata[RES_W-1:0];
                REG_RESPONSE_MODE:    response_mode_reg    <= pwdata[MODE_W-1:0];
                REG_SLOPE_SELECT:     slope_select_reg     <= pwdata[0];
                default:              ;
            endcase
        end
    end

    // Register read-back, zero-extended to the bus width.
    always_comb
    begin
        unique case (cfg_idx)
            REG_CUTOFF_BASE:      prdata = APB_DATA_W'(cutoff_base_reg);
            REG_CUTOFF_OFFSET:    prdata = APB_DATA_W'(unsigned'(cutoff_offset_reg));
            REG_RESONANCE_AMOUNT: prdata = APB_DATA_W'(resonance_amount_reg);
            REG_RESPONSE_MODE:    prdata = APB_DATA_W'(response_mode_reg);
            REG_SLOPE_SELECT:     prdata = APB_DATA_W'(slope_select_reg);
            default:              prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Effective cutoff: base plus modulation, clamped to 0..0.999.
    // ------------------------------------------------------------------
    logic signed [CUTOFF_W+1:0] cut_sum;
    logic [CUTOFF_W-1:0]        cutoff_eff;

    assign cut_sum = $signed({2'b00, cutoff_base_reg}) + (CUTOFF_W + 2)'(cutoff_offset_reg);

    always_comb
    begin
        if (cut_sum < 0)
        begin
            cutoff_eff = '0;
        end
        else if (cut_sum > $signed({2'b00, CUTOFF_MAX}))
        begin
            cutoff_eff = CUTOFF_MAX;
        end
        else
        begin
            cutoff_eff = cut_sum[CUTOFF_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Feedback gain: 2r + floor((r << 17) / (1 - cutoff)), restoring division
    // producing one quotient bit per cycle. The quotient shifts into the dividend
    // register as the dividend bits shift out.
    // ------------------------------------------------------------------
    logic                   div_start_reg;
    logic [DIV_CNT_W-1:0]   div_cnt_reg;
    logic [DIV_N_W-1:0]     div_n_reg;
    logic [DIV_D_W-1:0]     div_rem_reg;
    logic [DIV_D_W-1:0]     div_d_reg;
    logic [FB_W-1:0]        feedback_gain_reg;

    logic [DIV_D_W:0]       div_trial;
    logic                   div_ge;
    logic [DIV_D_W-1:0]     div_rem_next;
    logic [DIV_N_W-1:0]     div_q_next;
    logic [DIV_N_W:0]       fb_sum;
    logic [FB_W-1:0]        fb_next;
    logic [DIV_D_W-1:0]     div_den;

    assign div_den      = CUTOFF_ONE - DIV_D_W'(cutoff_eff);
    assign div_trial    = {div_rem_reg, div_n_reg[DIV_N_W-1]};
    assign div_ge       = div_trial >= {1'b0, div_d_reg};
    assign div_rem_next = div_ge ? DIV_D_W'(div_trial - {1'b0, div_d_reg})
                                 : div_trial[DIV_D_W-1:0];
    assign div_q_next   = {div_n_reg[DIV_N_W-2:0], div_ge};
    assign fb_sum       = (DIV_N_W + 1)'({resonance_amount_reg, 1'b0})
                        + (DIV_N_W + 1)'(div_q_next);
    assign fb_next      = (fb_sum > (DIV_N_W + 1)'(FEEDBACK_MAX)) ? FEEDBACK_MAX
                                                                  : fb_sum[FB_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_start_reg     <= 1'b0;
            div_cnt_reg       <= '0;
            feedback_gain_reg <= '0;
        end
        else
        begin
            div_start_reg <= cfg_hit;
            if (div_start_reg)
            begin
                div_cnt_reg <= DIV_CNT_W'(DIV_N_W);
            end
            else if (div_cnt_reg != '0)
            begin
                div_cnt_reg <= div_cnt_reg - 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(1))
                begin
                    feedback_gain_reg <= fb_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_start_reg)
        begin
            div_n_reg   <= {resonance_amount_reg, (DIV_N_W - RES_W)'(0)};
            div_rem_reg <= '0;
            div_d_reg   <= div_den;
        end
        else if (div_cnt_reg != '0)
        begin
            div_n_reg   <= div_q_next;
            div_rem_reg <= div_rem_next;
        end
    end

    // ------------------------------------------------------------------
    // Microcoded datapath. Each nonzero sample runs the program in the package
    // table; a zero sample jumps straight to the output step.
    // ------------------------------------------------------------------
    logic                          busy_reg,   busy_next;
    logic [STEP_W-1:0]             step_reg,   step_next;
    logic signed [SAMPLE_BITS-1:0] x_reg,      x_next;
    logic                          zero_reg,   zero_next;
    logic signed [POLE_BITS-1:0]   acc_reg,    acc_next;
    logic signed [PROD_W-1:0]      prod_reg,   prod_next;
    logic signed [POLE_BITS-1:0]   pole_reg    [NUM_POLES];
    logic signed [POLE_BITS-1:0]   pole_next   [NUM_POLES];
    logic                          out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] sample_out_reg, sample_out_next;

    ucode_t                        uc;
    logic                          accept;
    logic                          out_fire;
    logic signed [POLE_BITS-1:0]   pole_rd;
    logic signed [POLE_BITS-1:0]   opa;
    logic signed [COEF_W-1:0]      coef;
    logic signed [POLE_BITS-1:0]   term;
    logic signed [POLE_BITS-1:0]   alu;
    logic signed [POLE_BITS-1:0]   tail;
    logic signed [POLE_BITS-1:0]   hp_sub;
    logic signed [63:0]            y_wide;
    logic signed [SAMPLE_BITS-1:0] y_sat;

    assign uc       = ucode_rom(step_reg);
    assign in_ready = !busy_reg && !div_start_reg && (div_cnt_reg == '0);
    assign accept   = in_valid && in_ready;
    assign out_fire = busy_reg && (uc.op == OP_OUT) && (!out_valid_reg || out_ready);

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

    // Operand selection and the single adder / multiplier.
    assign pole_rd = pole_reg[uc.rd];

    always_comb
    begin
        case (uc.src)
            SRC_ACC:  opa = acc_reg;
            SRC_X:    opa = POLE_BITS'(x_reg);
            SRC_P0:   opa = pole_reg[0];
            default:  opa = pole_rd;
        endcase
    end

    assign coef = (uc.coef == COEF_FB) ? $signed({1'b0, feedback_gain_reg})
                                       : $signed(COEF_W'(cutoff_eff));
    // The product is scaled back by 16 bits, rounding toward minus infinity.
    assign term = sat_pole(64'(prod_reg >>> FRAC_SHIFT));
    assign alu  = (uc.op == OP_SUB) ? sat_pole(64'(opa) - 64'(pole_rd))
                                    : sat_pole(64'(opa) + 64'(term));

    // Response selection. In two-pole mode the tail is pole 1 and highpass subtracts pole 0.
    assign tail   = slope_select_reg ? pole_reg[3] : pole_reg[1];
    assign hp_sub = slope_select_reg ? pole_reg[3] : pole_reg[0];

    always_comb
    begin
        case (mode_t'(response_mode_reg))
            MODE_LOWPASS:  y_wide = 64'(tail);
            MODE_BANDPASS: y_wide = 64'(pole_reg[0]) - 64'(tail);
            MODE_HIGHPASS: y_wide = 64'(x_reg) - 64'(hp_sub);
            default:       y_wide = 64'(x_reg);
        endcase
    end

    assign y_sat = zero_reg ? '0 : sat_sample(y_wide);

    always_comb
    begin
        busy_next       = busy_reg;
        step_next       = step_reg;
        x_next          = x_reg;
        zero_next       = zero_reg;
        acc_next        = acc_reg;
        prod_next       = prod_reg;
        pole_next       = pole_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        sample_out_next = sample_out_reg;

        if (accept)
        begin
            busy_next = 1'b1;
            x_next    = sample_in;
            zero_next = (sample_in == '0);
            step_next = (sample_in == '0) ? STEP_OUT : '0;
        end
        else if (busy_reg)
        begin
            if (uc.br_two && !slope_select_reg)
            begin
                step_next = uc.target;
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end

            unique case (uc.op)
                OP_SUB:
                begin
                    acc_next = alu;
                end
                OP_MUL:
                begin
                    prod_next = coef * acc_reg;
                end
                OP_ADD:
                begin
                    acc_next = alu;
                    if (uc.wr)
                    begin
                        pole_next[uc.rd] = alu;
                    end
                end
                OP_OUT:
                begin
                    // Hold at the output step until the output register is free.
                    step_next = step_reg;
                    if (out_fire)
                    begin
                        out_valid_next  = 1'b1;
                        sample_out_next = y_sat;
                        busy_next       = 1'b0;
                    end
                end
                default:
                begin
                    step_next = step_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            pole_reg      <= '{default: '0};
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            pole_reg      <= pole_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        zero_reg       <= zero_next;
        acc_reg        <= acc_next;
        prod_reg       <= prod_next;
        sample_out_reg <= sample_out_next;
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // No request is taken while the feedback gain is being recomputed.
    a_no_accept_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
        (div_cnt_reg != '0) |-> !in_ready)
        else $error("input accepted while the feedback divider is running");

    // A zero sample goes straight to the output step.
    a_zero_skips_program: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (sample_in == '0)) |=> (busy_reg && (step_reg == STEP_OUT)))
        else $error("zero sample did not skip the filter program");

    // Finishing the output step presents a result and frees the sequencer.
    a_out_step_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && (uc.op == OP_OUT) && (!out_valid_reg || out_ready))
            |=> (out_valid && !busy_reg))
        else $error("output step did not deliver a result");

endmodule

### tb/rfpf_response_checker.sv
// Checker for the resonant filter: tracks register writes, predicts every output sample and compares.
`timescale 1ns / 1ps

module rfpf_response_checker
    import rfpf_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [ADDR_W-1:0]             paddr,
    input  logic [APB_DATA_W-1:0]         pwdata,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample_out,
    output int                            mismatch_count,
    output int                            pending_count,
    output int                            checked_count
);

    // Shadow copy of the register file and of the derived feedback gain.
    logic [CUTOFF_W-1:0]          cut_base;
    logic signed [OFFSET_W-1:0]   cut_offset;
    logic [RES_W-1:0]             resonance;
    mode_t                        mode;
    logic                         four_pole;
    logic [FB_W-1:0]              fb_gain;
    logic signed [POLE_BITS-1:0]  poles [NUM_POLES];

    logic signed [SAMPLE_BITS-1:0] expected_samples [$];

    function automatic longint clamp_bits(input longint v, input int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
        begin
            return hi;
        end
        if (v < lo)
        begin
            return lo;
        end
        return v;
    endfunction

    function automatic longint clamp_pole(input longint v);
        return clamp_bits(v, POLE_BITS);
    endfunction

    function automatic longint effective_cutoff(input longint base, input longint offset);
        longint c;
        c = base + offset;
        if (c < 0)
        begin
            c = 0;
        end
        else if (c > longint'(CUTOFF_MAX))
        begin
            c = longint'(CUTOFF_MAX);
        end
        return c;
    endfunction

    // One one-pole section: the pole moves toward its source by the cutoff fraction.
    function automatic longint pole_step(input longint pole, input longint src, input longint c);
        longint diff;
        diff = clamp_pole(src - pole);
        return clamp_pole(pole + ((c * diff) >>> 16));
    endfunction

    // Runs one sample through the cascade, updates the shadow poles and returns the output.
    function automatic logic signed [SAMPLE_BITS-1:0] filter_next_sample(
        input logic signed [SAMPLE_BITS-1:0] smp);
        longint x;
        longint c;
        longint g;
        longint d;
        longint fb_term;
        longint y;
        longint p [NUM_POLES];
        if (smp == 0)
        begin
            return '0;
        end
        x = smp;
        c = effective_cutoff(cut_base, cut_offset);
        for (int k = 0; k < NUM_POLES; k++)
        begin
            p[k] = poles[k];
        end
        // Resonance: the gain is split into integer and fraction parts so the
        // fraction product rounds toward minus infinity.
        g = fb_gain;
        d = clamp_pole(p[0] - p[1]);
        fb_term = clamp_pole((g / 65536) * d + (((g % 65536) * d) >>> 16));
        p[0] = pole_step(p[0], clamp_pole(x + fb_term), c);
        p[1] = pole_step(p[1], p[0], c);
        if (four_pole)
        begin
            p[2] = pole_step(p[2], p[1], c);
            p[3] = pole_step(p[3], p[2], c);
            case (mode)
                MODE_LOWPASS:  y = p[3];
                MODE_BANDPASS: y = p[0] - p[3];
                MODE_HIGHPASS: y = x - p[3];
                default:       y = x;
            endcase
        end
        else
        begin
            case (mode)
                MODE_LOWPASS:  y = p[1];
                MODE_BANDPASS: y = p[0] - p[1];
                MODE_HIGHPASS: y = x - p[0];
                default:       y = x;
            endcase
        end
        for (int k = 0; k < NUM_POLES; k++)
        begin
            poles[k] = POLE_BITS'(p[k]);
        end
        return SAMPLE_BITS'(clamp_bits(y, SAMPLE_BITS));
    endfunction

    function automatic void note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%0t: %s", $realtime, msg);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic signed [SAMPLE_BITS-1:0] want;
        longint c_now;
        longint gain;
        if (!rst_n)
        begin
            cut_base       = CUTOFF_RESET;
            cut_offset     = '0;
            resonance      = '0;
            mode           = MODE_LOWPASS;
            four_pole      = 1'b1;
            fb_gain        = '0;
            for (int k = 0; k < NUM_POLES; k++)
            begin
                poles[k] = '0;
            end
            expected_samples.delete();
            mismatch_count = 0;
            pending_count  = 0;
            checked_count  = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_W-1:2])
                    REG_CUTOFF_BASE:      cut_base   = pwdata[CUTOFF_W-1:0];
                    REG_CUTOFF_OFFSET:    cut_offset = pwdata[OFFSET_W-1:0];
                    REG_RESONANCE_AMOUNT: resonance  = pwdata[RES_W-1:0];
                    REG_RESPONSE_MODE:    mode       = mode_t'(pwdata[MODE_W-1:0]);
                    REG_SLOPE_SELECT:     four_pole  = pwdata[0];
                    default: ;
                endcase
                c_now = effective_cutoff(cut_base, cut_offset);
                gain = 2 * longint'(resonance)
                     + (longint'(resonance) << 17) / (longint'(CUTOFF_ONE) - c_now);
                fb_gain = (gain > longint'(FEEDBACK_MAX)) ? FEEDBACK_MAX : gain[FB_W-1:0];
            end
            // The result leaving at this edge belongs to an older request, so pop first.
            if (out_valid && out_ready)
            begin
                if (expected_samples.size() == 0)
                begin
                    note_failure($sformatf("sample_out %0d arrived with nothing outstanding",
                                           sample_out));
                end
                else
                begin
                    want = expected_samples.pop_front();
                    checked_count++;
                    if (sample_out !== want)
                    begin
                        note_failure($sformatf("sample_out mismatch: expected %0d, got %0d",
                                               want, sample_out));
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                expected_samples.push_back(filter_next_sample(sample_in));
            end
            pending_count = expected_samples.size();
        end
    end

endmodule

### tb/tb_resonant_four_pole_filter.sv
// Top of the resonant filter testbench: clock, reset, register setup, sample stimulus and verdict.
`timescale 1ns / 1ps

// The testbench programs the filter through its APB port while nothing is in flight, then
// streams audio-like sample requests through it. A checker module beside the filter watches
// the register writes and both streams, predicts each filtered sample and counts mismatches.
// This module only makes stimulus and decides the verdict from the checker's counts.
module tb_resonant_four_pole_filter;
    import rfpf_pkg::*;

    typedef enum int {
        WAVE_NOISE,
        WAVE_SQUARE,
        WAVE_QUIET,
        WAVE_RAMP
    } wave_t;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_HI = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_LO = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam int RANDOM_PHASES   = 12;
    localparam int PHASE_REQUESTS  = 150;

    // Opening requests under the reset settings: both rails repeated so the poles charge,
    // zero in the middle of a charged state, the smallest steps and alternating bit patterns.
    localparam logic signed [SAMPLE_BITS-1:0] OPENING [12] = '{
        SAMPLE_HI, SAMPLE_HI, SAMPLE_HI, SAMPLE_LO, SAMPLE_LO, '0,
        24'sd1, -24'sd1, 24'sh555555, 24'shAAAAAA, '0, SAMPLE_HI
    };

    logic                          clk;
    logic                          rst_n     = 1'b0;
    logic                          psel      = 1'b0;
    logic                          penable   = 1'b0;
    logic                          pwrite    = 1'b0;
    logic [ADDR_W-1:0]             paddr     = '0;
    logic [APB_DATA_W-1:0]         pwdata    = '0;
    logic [APB_DATA_W-1:0]         prdata;
    logic                          pready;
    logic                          in_valid  = 1'b0;
    logic                          in_ready;
    logic signed [SAMPLE_BITS-1:0] sample_in = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic signed [SAMPLE_BITS-1:0] sample_out;

    // Percent chance per cycle that the sender holds back or the receiver stalls.
    int send_gap_pct = 0;
    int hold_pct     = 0;

    int requests_sent   = 0;
    int settings_loaded = 0;
    int mismatch_count;
    int pending_count;
    int checked_count;

    resonant_four_pole_filter i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out)
    );

    rfpf_response_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sample_in      (sample_in),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sample_out     (sample_out),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .checked_count  (checked_count)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // The receiver decides afresh every cycle whether it takes a result.
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= hold_pct);
    end

    // One APB write: a setup cycle, then an access cycle held until pready. The select is
    // left high so that writes can follow back to back; the caller closes the transfer.
    // Bits above the register width carry random junk, which the block has to ignore.
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] value,
                             input int width);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= (APB_DATA_W'($urandom()) << width)
                 | (value & ((APB_DATA_W'(1) << width) - 1));
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
    endtask

    // Writes every register, plus one write to an unused address that must change nothing.
    task automatic load_settings(input int unsigned base, input int offset, input int unsigned res,
                                 input mode_t m, input logic four);
        logic [REG_IDX_W-1:0] spare;
        spare = REG_IDX_W'(REG_SLOPE_SELECT + $urandom_range(1, 3));
        write_reg(REG_CUTOFF_BASE, base, CUTOFF_W);
        write_reg(REG_CUTOFF_OFFSET, offset, OFFSET_W);
        write_reg(REG_RESONANCE_AMOUNT, res, RES_W);
        write_reg(REG_RESPONSE_MODE, APB_DATA_W'(m), MODE_W);
        write_reg(REG_SLOPE_SELECT, APB_DATA_W'(four), 1);
        write_reg(spare, $urandom(), 0);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        settings_loaded++;
    endtask

    // Presents one sample request after a random gap and holds it until it is accepted.
    // Valid stays high from one request to the next when no gap falls between them.
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        sample_in <= value;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        requests_sent++;
    endtask

    // Stops sending and waits until every outstanding result has come back, so the
    // registers can be rewritten safely. Each request gives exactly one result, so the
    // block is idle once the last one is taken.
    task automatic drain();
        in_valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (pending_count != 0);
        @(posedge clk);
    endtask

    initial
    begin
        wave_t                         wave;
        int                            period;
        int                            amp;
        int unsigned                   base;
        int                            offset;
        int unsigned                   res;
        mode_t                         m;
        logic                          four;
        logic                          high_half;
        logic signed [SAMPLE_BITS-1:0] level;
        logic signed [SAMPLE_BITS-1:0] ramp_step;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. The first requests run on the reset settings: half-scale cutoff,
        // no resonance, four-pole lowpass.
        send_gap_pct = 21;
        hold_pct     = 84;
        foreach (OPENING[i])
        begin
            send_sample(OPENING[i]);
        end
        drain();

        // Cutoff pushed past its clamp with full resonance: the feedback gain is at its
        // largest, and rail-to-rail swings drive the poles into saturation.
        load_settings(65535, 65535, 65535, MODE_LOWPASS, 1'b1);
        for (int i = 0; i < 8; i++)
        begin
            send_sample(i[0] ? SAMPLE_LO : SAMPLE_HI);
        end
        drain();

        // Cutoff clamped to zero: the poles must hold still whatever comes in.
        load_settings(0, -65536, 65535, MODE_BANDPASS, 1'b0);
        send_sample(SAMPLE_HI);
        send_sample(SAMPLE_LO);
        send_sample('0);
        send_sample(24'sd12345);
        drain();

        // Random part. The first eight phases walk through every response mode with both
        // slopes; the last four pick both at random. Idling goes from a busy receiver, to a slow
        // sender, to none at all.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase < 4)
            begin
                send_gap_pct = 21;
                hold_pct     = 84;
            end
            else if (phase < 8)
            begin
                send_gap_pct = 84;
                hold_pct     = 21;
            end
            else
            begin
                send_gap_pct = 0;
                hold_pct     = 0;
            end

            if (phase < 8)
            begin
                m    = mode_t'(phase % 4);
                four = 1'((phase / 4) % 2);
            end
            else
            begin
                m    = mode_t'($urandom_range(0, 3));
                four = 1'($urandom_range(0, 1));
            end

            // Rails now and then, otherwise anywhere; half the time the offset is a small
            // modulation so the cutoff is often not clamped.
            case ($urandom_range(0, 7))
                0:       base = 0;
                1:       base = 65535;
                default: base = $urandom_range(0, 65535);
            endcase
            case ($urandom_range(0, 7))
                0:       offset = -65536;
                1:       offset = 65535;
                2, 3:    offset = int'($urandom_range(0, 131071)) - 65536;
                default: offset = int'($urandom_range(0, 8191)) - 4096;
            endcase
            case ($urandom_range(0, 5))
                0:       res = 0;
                1:       res = 65535;
                default: res = $urandom_range(0, 65535);
            endcase
            load_settings(base, offset, res, m, four);

            wave      = wave_t'($urandom_range(0, 3));
            period    = $urandom_range(2, 40);
            amp       = $urandom_range(1, 8388607);
            high_half = 1'b0;
            level     = SAMPLE_BITS'($urandom());
            ramp_step = SAMPLE_BITS'($urandom_range(1, 1 << 20));
            for (int n = 0; n < PHASE_REQUESTS; n++)
            begin
                case (wave)
                    WAVE_NOISE:
                    begin
                        level = ($urandom_range(0, 15) == 0) ? '0 : SAMPLE_BITS'($urandom());
                    end
                    WAVE_SQUARE:
                    begin
                        if (n % period == 0)
                        begin
                            high_half = !high_half;
                        end
                        level = SAMPLE_BITS'(high_half ? amp : -amp);
                    end
                    WAVE_QUIET:
                    begin
                        level = SAMPLE_BITS'(int'($urandom_range(0, 511)) - 256);
                    end
                    default:
                    begin
                        // A sawtooth that wraps through both rails.
                        level = level + ramp_step;
                    end
                endcase
                send_sample(level);
            end
            drain();
        end

        // Let the pipeline settle in case anything stray is still on its way out.
        repeat (40) @(posedge clk);

        $display("Checked %0d of %0d sample requests over %0d register settings.",
                 checked_count, requests_sent, settings_loaded);
        $display("Covered all four responses at both slopes, clamped cutoffs and full resonance.");
        if (mismatch_count == 0 && pending_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Hard stop far beyond the slowest correct run.
    initial
    begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
